@@ hw/rtl/bitsel_pkg.sv @@
// Shared constants, codes and helper functions for the bit array select engine.
// No dependencies; imported by bit_array_select_engine_unit.
`timescale 1ns / 1ps
`default_nettype none

package bitsel_pkg;

    localparam int STORE_BITS = 4096;
    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = (STORE_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int IDX_W      = 12;
    localparam int LEN_W      = 13;
    localparam int PC_W       = BIT_AW + 1;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SELECT = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + 4'(b[i]);
        end
        return c;
    endfunction

    function automatic logic [PC_W-1:0] pop64(input logic [WORD_BITS-1:0] v);
        logic [PC_W-1:0] c;
        c = '0;
        for (int i = 0; i < WORD_BITS / 8; i++) begin
            c = c + PC_W'(pop8(v[i*8 +: 8]));
        end
        return c;
    endfunction

    // Bits of word w that lie below the used length len.
    function automatic logic [WORD_BITS-1:0] live_mask(input logic [WORD_AW-1:0] w,
                                                       input logic [LEN_W-1:0] len);
        logic [LEN_W-BIT_AW-1:0] full_words;
        logic [BIT_AW-1:0]       rem;
        logic [LEN_W-BIT_AW-1:0] wx;
        full_words = len[LEN_W-1:BIT_AW];
        rem        = len[BIT_AW-1:0];
        wx         = (LEN_W-BIT_AW)'(w);
        if (wx < full_words) begin
            return '1;
        end else if (wx == full_words) begin
            return (WORD_BITS'(1) << rem) - WORD_BITS'(1);
        end else begin
            return '0;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bit_array_select_engine_unit.sv @@
// Bit array with read, write, clear and rank-select; state in one word memory.
// Depends on bitsel_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  fields (tdata / tuser, lowest bit first)
//  s         in         tdata: bit_index, bit_value, rank   tuser: op
//  m         out        tdata: bit_out, found_index, ones_count, is_empty, is_full
//                       tuser: status
//  cfg       in         wdata: array_bits
//
//  Clear goes from accept straight to the done state, which loads the result register
//  once it is free. Other items sweep the used words, one memory read per cycle; a
//  select then locates the bit inside its word (byte then bit).
//  The word store needs no clearing pass: per-word valid bits reset at once.
//  A new item is taken as soon as the previous result sits in the output register.
module bit_array_select_engine_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_wdata,   // array_bits
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,     // bit_index[11:0], bit_value, rank[11:0], pad
    input  wire logic [1:0]  i_s_tuser,     // op
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,     // bit_out, found_index[11:0], ones_count[12:0],
                                            // is_empty, is_full, pad
    output logic [1:0]       o_m_tuser      // status
);
    import bitsel_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_BYTE,
        S_BIT,
        S_DONE
    } t_state;

    localparam int NW_W = WORD_AW + 1;

    t_state                 r_state, n_state;
    logic [LEN_W-1:0]       r_cfg_len;
    t_op                    r_op, n_op;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_val, n_val;
    logic                   r_inrange, n_inrange;
    logic [IDX_W-1:0]       r_left, n_left;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [NW_W-1:0]        r_nwords, n_nwords;
    logic [NW_W-1:0]        r_issue, n_issue;
    logic                   r_p1, n_p1;
    logic [WORD_AW-1:0]     r_p1_w, n_p1_w;
    logic                   r_rd_valid, n_rd_valid;
    logic [WORD_BITS-1:0]   r_rd_data;
    logic                   r_p2, n_p2;
    logic [WORD_AW-1:0]     r_p2_w, n_p2_w;
    logic [WORD_BITS-1:0]   r_v, n_v;
    logic [PC_W-1:0]        r_pc, n_pc;
    logic [LEN_W-1:0]       r_count, n_count;
    logic                   r_hit, n_hit;
    logic [WORD_BITS-1:0]   r_sel_word, n_sel_word;
    logic [WORD_AW-1:0]     r_sel_w, n_sel_w;
    logic [2:0]             r_byte_i, n_byte_i;
    logic [2:0]             r_bit_i, n_bit_i;
    logic                   r_bit_out, n_bit_out;
    logic [IDX_W-1:0]       r_found, n_found;
    logic [WORD_COUNT-1:0]  r_valid, n_valid;
    logic                   r_out_valid, n_out_valid;
    logic [31:0]            r_out_data, n_out_data;
    logic [1:0]             r_out_user, n_out_user;

    logic [WORD_BITS-1:0]   r_mem [WORD_COUNT];

    logic                   s_accept;
    logic [LEN_W-1:0]       len_sat;
    logic                   issuing;
    logic [WORD_BITS-1:0]   w1, mod_word;
    logic                   tgt, wr_en;
    logic [7:0]             sel_byte;
    logic [3:0]             pc8;
    logic [1:0]             status;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign len_sat    = (r_cfg_len > LEN_W'(STORE_BITS)) ? LEN_W'(STORE_BITS) : r_cfg_len;
    assign issuing    = (r_state == S_SWEEP) && (r_issue < r_nwords);

    // word stage: merge the write, mask to the live length
    assign w1  = r_rd_valid ? r_rd_data : '0;
    assign tgt = r_p1 && r_inrange && (r_p1_w == r_idx[IDX_W-1:BIT_AW])
                 && (r_op == OP_READ || r_op == OP_WRITE);
    assign wr_en = tgt && (r_op == OP_WRITE);

    always_comb begin
        mod_word = w1;
        if (wr_en) begin
            mod_word[r_idx[BIT_AW-1:0]] = r_val;
        end
    end

    assign sel_byte = r_sel_word[{r_byte_i, 3'b000} +: 8];
    assign pc8      = pop8(sel_byte);

    always_comb begin
        case (r_op)
            OP_READ, OP_WRITE: status = r_inrange ? ST_OK : ST_RANGE;
            OP_SELECT:         status = r_hit ? ST_OK : ST_NOTFOUND;
            default:           status = ST_OK;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_val       = r_val;
        n_inrange   = r_inrange;
        n_left      = r_left;
        n_len       = r_len;
        n_nwords    = r_nwords;
        n_issue     = r_issue;
        n_p1        = issuing;
        n_p1_w      = r_issue[WORD_AW-1:0];
        n_rd_valid  = r_valid[r_issue[WORD_AW-1:0]];
        n_p2        = r_p1;
        n_p2_w      = r_p1_w;
        n_v         = mod_word & live_mask(r_p1_w, r_len);
        n_pc        = pop64(mod_word & live_mask(r_p1_w, r_len));
        n_count     = r_count;
        n_hit       = r_hit;
        n_sel_word  = r_sel_word;
        n_sel_w     = r_sel_w;
        n_byte_i    = r_byte_i;
        n_bit_i     = r_bit_i;
        n_bit_out   = r_bit_out;
        n_found     = r_found;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        if (wr_en) begin
            n_valid[r_p1_w] = 1'b1;
        end
        if (tgt && r_op == OP_READ) begin
            n_bit_out = w1[r_idx[BIT_AW-1:0]];
        end
        if (issuing) begin
            n_issue = r_issue + NW_W'(1);
        end

        // count stage: running total and rank search over whole words
        if (r_p2) begin
            n_count = r_count + LEN_W'(r_pc);
            if (r_op == OP_SELECT && !r_hit) begin
                if (r_left < IDX_W'(r_pc)) begin
                    n_hit      = 1'b1;
                    n_sel_word = r_v;
                    n_sel_w    = r_p2_w;
                end else begin
                    n_left = r_left - IDX_W'(r_pc);
                end
            end
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op      = t_op'(i_s_tuser);
                    n_idx     = i_s_tdata[11:0];
                    n_val     = i_s_tdata[12];
                    n_left    = i_s_tdata[24:13];
                    n_len     = len_sat;
                    n_inrange = (LEN_W'(i_s_tdata[11:0]) < len_sat);
                    n_nwords  = len_sat[LEN_W-1:BIT_AW] + NW_W'(|len_sat[BIT_AW-1:0]);
                    n_issue   = '0;
                    n_count   = '0;
                    n_hit     = 1'b0;
                    n_bit_out = 1'b0;
                    n_found   = '0;
                    if (t_op'(i_s_tuser) == OP_CLEAR) begin
                        n_valid = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                if (!issuing && !r_p1 && !r_p2) begin
                    n_byte_i = '0;
                    n_state  = (r_op == OP_SELECT && r_hit) ? S_BYTE : S_DONE;
                end
            end
            S_BYTE: begin
                if (r_left < IDX_W'(pc8)) begin
                    n_bit_i = '0;
                    n_state = S_BIT;
                end else begin
                    n_left   = r_left - IDX_W'(pc8);
                    n_byte_i = r_byte_i + 3'd1;
                end
            end
            S_BIT: begin
                if (sel_byte[r_bit_i]) begin
                    if (r_left == '0) begin
                        n_found = {r_sel_w, r_byte_i, r_bit_i};
                        n_state = S_DONE;
                    end else begin
                        n_left = r_left - IDX_W'(1);
                    end
                end
                n_bit_i = r_bit_i + 3'd1;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = status;
                    n_out_data  = {4'b0000,
                                   (r_count == r_len),
                                   (r_count == '0),
                                   r_count,
                                   r_found,
                                   r_bit_out};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_len   <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_cfg_len <= i_cfg_wdata;
            end
            r_p1        <= n_p1;
            r_p2        <= n_p2;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_idx      <= n_idx;
        r_val      <= n_val;
        r_inrange  <= n_inrange;
        r_left     <= n_left;
        r_len      <= n_len;
        r_nwords   <= n_nwords;
        r_issue    <= n_issue;
        r_p1_w     <= n_p1_w;
        r_rd_valid <= n_rd_valid;
        r_p2_w     <= n_p2_w;
        r_v        <= n_v;
        r_pc       <= n_pc;
        r_count    <= n_count;
        r_hit      <= n_hit;
        r_sel_word <= n_sel_word;
        r_sel_w    <= n_sel_w;
        r_byte_i   <= n_byte_i;
        r_bit_i    <= n_bit_i;
        r_bit_out  <= n_bit_out;
        r_found    <= n_found;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    // word store: one read and one write port, read data registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_issue[WORD_AW-1:0]];
        if (wr_en) begin
            r_mem[r_p1_w] <= mod_word;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_NOTFOUND) |-> (o_m_tdata[12:1] == '0))
        else $error("select miss carries a nonzero index");

    a_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_SWEEP && r_op == OP_WRITE))
        else $error("store written outside a write sweep");

    a_pipe_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1 || r_p2) |-> (r_state == S_SWEEP))
        else $error("sweep pipeline busy outside sweep");

    a_bit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIT) |=> (r_state == S_BIT || r_state == S_DONE))
        else $error("bit search left by an unexpected path");

endmodule

`default_nettype wire

@@ tb/bit_array_select_engine_unit_tb.sv @@
// Self-checking testbench for bit_array_select_engine_unit: read, write, clear and
// rank-select items checked against an in-bench model of the bit array.
// Depends on bitsel_pkg and the RTL of bit_array_select_engine_unit.
`timescale 1ns / 1ps

module bit_array_select_engine_unit_tb;

    import bitsel_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_GAP   = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_status          status;
        logic             bit_out;
        logic [IDX_W-1:0] found_index;
        logic [LEN_W-1:0] ones_count;
        logic             is_empty;
        logic             is_full;
    } t_sel_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [12:0] i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic [31:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    // array model
    logic [STORE_BITS-1:0] array_bits_q = '0;
    int unsigned           length_cfg   = 0;

    t_sel_result expected_results[$];
    t_sel_result got_result;
    t_sel_result want_result;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned snd_idle_pct   = 0;
    int unsigned rcv_stall_pct  = 0;
    logic        hold_on        = 1'b0;
    event        hold_go;

    bit_array_select_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bit_array_select_engine_unit verification failed");
            $finish;
        end
    end

    // Lengths above the maximum saturate.
    function automatic int unsigned used_length();
        return (length_cfg > STORE_BITS) ? STORE_BITS : length_cfg;
    endfunction

    function automatic int unsigned live_ones();
        int unsigned c;
        int unsigned len;
        c   = 0;
        len = used_length();
        for (int i = 0; i < len; i++) begin
            c += 32'(array_bits_q[i]);
        end
        return c;
    endfunction

    function automatic t_sel_result predict_array_op(input t_op op, input logic [11:0] idx,
                                                     input logic val, input logic [11:0] rank);
        t_sel_result r;
        int unsigned len;
        int unsigned left;
        int unsigned ones;
        r    = '0;
        len  = used_length();
        left = 32'(rank);
        case (op)
            OP_READ, OP_WRITE: begin
                if (idx >= len) begin
                    r.status = ST_RANGE;
                end else if (op == OP_READ) begin
                    r.bit_out = array_bits_q[idx];
                end else begin
                    array_bits_q[idx] = val;
                end
            end
            OP_SELECT: begin
                r.status = ST_NOTFOUND;
                for (int i = 0; i < len; i++) begin
                    if (array_bits_q[i]) begin
                        if (left == 0) begin
                            r.status      = ST_OK;
                            r.found_index = i[IDX_W-1:0];
                            break;
                        end
                        left--;
                    end
                end
            end
            default: begin
                array_bits_q = '0;
            end
        endcase
        ones         = live_ones();
        r.ones_count = ones[LEN_W-1:0];
        r.is_empty   = (ones == 0);
        r.is_full    = (ones == len);
        return r;
    endfunction

    // Long receiver hold-off, counted here once requested.
    always begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Result side: random stalls, plus a long hold-off when asked for.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            got_result.status      = t_status'(o_m_tuser);
            got_result.bit_out     = o_m_tdata[0];
            got_result.found_index = o_m_tdata[12:1];
            got_result.ones_count  = o_m_tdata[25:13];
            got_result.is_empty    = o_m_tdata[26];
            got_result.is_full     = o_m_tdata[27];
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result item, tdata %h tuser %h",
                             $realtime, o_m_tdata, o_m_tuser);
            end else begin
                want_result = expected_results.pop_front();
                if (got_result != want_result) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $write("%0t: mismatch exp st=%0d bit=%0d idx=%0d ones=%0d e=%0d f=%0d",
                               $realtime, want_result.status, want_result.bit_out,
                               want_result.found_index, want_result.ones_count,
                               want_result.is_empty, want_result.is_full);
                        $display(" | got st=%0d bit=%0d idx=%0d ones=%0d e=%0d f=%0d",
                                 got_result.status, got_result.bit_out,
                                 got_result.found_index, got_result.ones_count,
                                 got_result.is_empty, got_result.is_full);
                    end
                end
            end
        end
        if (hold_on) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    task automatic send_item(input t_op op, input logic [11:0] idx, input logic val,
                             input logic [11:0] rank);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, rank, val, idx};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_results.push_back(predict_array_op(op, idx, val, rank));
    endtask

    // Stop offering, let every expected result come back, then a short pause.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_array_length(input int unsigned bits);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= bits[12:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        length_cfg = bits;
    endtask

    // Mostly in-range writes and reads, selects near the live count, a few clears,
    // and some items with every field random.
    task automatic send_random_item();
        int unsigned len;
        int unsigned ones;
        int unsigned pick;
        logic [11:0] idx;
        logic [11:0] rank;
        len  = used_length();
        ones = live_ones();
        pick = $urandom_range(0, 99);
        idx  = 12'($urandom_range(0, 4095));
        rank = 12'($urandom_range(0, 4095));
        if (len != 0 && $urandom_range(0, 9) != 0)
            idx = 12'($urandom_range(0, len - 1));
        if ($urandom_range(0, 9) != 0)
            rank = 12'($urandom_range(0, ones + 1));
        if (pick < 40)
            send_item(OP_WRITE, idx, ($urandom_range(0, 9) < 7), rank);
        else if (pick < 65)
            send_item(OP_READ, idx, 1'($urandom_range(0, 1)), rank);
        else if (pick < 90)
            send_item(OP_SELECT, idx, 1'($urandom_range(0, 1)), rank);
        else if (pick < 93)
            send_item(OP_CLEAR, idx, 1'($urandom_range(0, 1)), rank);
        else
            send_item(t_op'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                      1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
    endtask

    task automatic test_nil_array();
        send_item(OP_READ, 12'd0, 1'b0, 12'd0);
        send_item(OP_WRITE, 12'd0, 1'b1, 12'd0);
        send_item(OP_SELECT, 12'd0, 1'b0, 12'd0);
    endtask

    task automatic test_saturated_length();
        set_array_length(8191);
        send_item(OP_WRITE, 12'd0, 1'b1, 12'd0);
        send_item(OP_WRITE, 12'd4095, 1'b1, 12'd0);
        send_item(OP_READ, 12'd4095, 1'b0, 12'd0);
        send_item(OP_READ, 12'd0, 1'b0, 12'd0);
        send_item(OP_SELECT, 12'd0, 1'b0, 12'd0);
        send_item(OP_SELECT, 12'd0, 1'b0, 12'd1);
        send_item(OP_SELECT, 12'd0, 1'b0, 12'd2);
        send_item(OP_SELECT, 12'd0, 1'b0, 12'd4095);
        send_item(OP_WRITE, 12'd4095, 1'b0, 12'd0);
        send_item(OP_READ, 12'd4095, 1'b0, 12'd0);
    endtask

    task automatic test_word_boundary();
        set_array_length(64);
        send_item(OP_READ, 12'd64, 1'b0, 12'd0);
        send_item(OP_WRITE, 12'd64, 1'b1, 12'd0);
        send_item(OP_WRITE, 12'd63, 1'b1, 12'd0);
        send_item(OP_SELECT, 12'd0, 1'b0, 12'd1);
    endtask

    // Bits beyond a shortened length stay in the store and reappear on growth.
    task automatic test_length_shrink_grow();
        set_array_length(1);
        send_item(OP_READ, 12'd0, 1'b0, 12'd0);
        set_array_length(4096);
        send_item(OP_READ, 12'd63, 1'b0, 12'd0);
    endtask

    task automatic test_clear();
        send_item(OP_CLEAR, 12'd0, 1'b0, 12'd0);
        send_item(OP_SELECT, 12'd0, 1'b0, 12'd0);
    endtask

    task automatic test_random_traffic();
        int unsigned lengths [10];
        lengths = '{1, 63, 64, 65, 200, 1000, 4095, 4096, 8191, 0};
        for (int p = 0; p < 10; p++) begin
            set_array_length((p == 9) ? $urandom_range(0, 8191) : lengths[p]);
            case (p % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 67; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 67; end
                default: begin snd_idle_pct = 9; rcv_stall_pct = 9; end
            endcase
            if ($urandom_range(0, 1) != 0)
                send_item(OP_CLEAR, 12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                          12'($urandom_range(0, 4095)));
            for (int n = 0; n < 80; n++) begin
                send_random_item();
            end
        end
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure_fill();
        set_array_length(4096);
        -> hold_go;
        for (int n = 0; n < 20; n++) begin
            send_random_item();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_nil_array();
        test_saturated_length();
        test_word_boundary();
        test_length_shrink_grow();
        test_clear();
        test_random_traffic();
        test_backpressure_fill();
        drain_results();
        repeat (SETTLE_GAP) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("bit_array_select_engine_unit verification clean");
        end else begin
            $display("bit_array_select_engine_unit verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bitsel_pkg.sv
hw/rtl/bit_array_select_engine_unit.sv
tb/bit_array_select_engine_unit_tb.sv
